/* rtl/adam_optimizer_update_macros.svh */
// assertion macros used by the checker file
`ifndef ADAM_OPTIMIZER_UPDATE_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_MACROS_SVH

// same-cycle implication
`define ADAM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adam port check failed");

// next-cycle implication
`define ADAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adam port check failed");

`endif

/* rtl/adam_pkg.sv */
// types, constants and codes of the adam optimizer update block
package adam_pkg;

   localparam int ELEMENTS_DEFAULT = 1024;
   localparam int GRAD_W  = 32;
   localparam int INDEX_W = 10;
   localparam int FRAC_W  = 24;
   localparam int COEF_W  = 25;
   localparam int EPS_W   = 40;
   localparam int CSR_W   = 40;
   localparam int VM_W    = 64;
   localparam int ROOT_W  = 32;
   localparam int ACC_W   = 96;
   localparam int DIV_W   = 96;
   localparam int DEN_W   = 49;

   localparam logic [COEF_W-1:0] ONE_Q24 = COEF_W'(1) << FRAC_W;
   localparam logic [23:0] FIRST_DECAY_RESET  = 24'd15099494;
   localparam logic [23:0] SECOND_DECAY_RESET = 24'd16760439;
   localparam logic [23:0] STEP_SIZE_RESET    = 24'd16777;
   localparam logic [EPS_W-1:0] STABILITY_RESET = 40'd10995;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad;
      logic [INDEX_W-1:0]       elem_index;
      logic                     last_elem;
   } req_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] update_value;
      logic [INDEX_W-1:0]       out_index;
      logic                     saturated;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_FIRST_DECAY,
      CSR_SECOND_DECAY,
      CSR_STEP_SIZE,
      CSR_STABILITY
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_M0, ST_M1, ST_M2, ST_V0, ST_V1, ST_V2, ST_V3,
      ST_C1, ST_C2, ST_C3, ST_DIV_MH, ST_DIV_VH, ST_SQ0, ST_SQRT,
      ST_N0, ST_N1, ST_N2, ST_N3, ST_DIV_UP, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      MUL_G_SQ, MUL_G_M, MUL_M_OLD, MUL_V_LO, MUL_V_HI, MUL_SQ_LO, MUL_SQ_HI,
      MUL_P1, MUL_P2, MUL_N_LO, MUL_N_HI
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_LOAD, ACC_LOAD_RND, ACC_ADD
   } acc_op_type;

   typedef enum logic [3:0] {
      CAP_NONE, CAP_GSQ, CAP_M, CAP_V, CAP_C1, CAP_C2, CAP_MH, CAP_VHAT, CAP_DEN,
      CAP_UPD_ZERO, CAP_UPD_DIV
   } cap_type;

   typedef enum logic [1:0] {
      DIV_MH, DIV_VH, DIV_UP
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        mem_rd;
      logic        mem_we;
      logic        clear_we;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        acc_sh32;
      cap_type     cap;
      logic        div_start;
      div_sel_type div_sel;
      logic        sqrt_start;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic div_done;
      logic sqrt_done;
      logic den_zero;
      logic out_busy;
   } dp_status_type;

endpackage

/* rtl/adam_optimizer_update.sv */
// Adam element update with bias correction, Q8.24 in and out. One request is
// worked at a time: an accept step, sequencing of the moment updates and correction
// factors on one shared 32x32 multiplier, three passes of the bit-serial divider,
// the digit-serial square root, the step-size product and the load of the output
// register. With a zero denominator the last divide is skipped. The output load
// waits while the previous result is still stalled. A finished result waits in the
// output register while the next request is taken. After reset every entry of the
// moment stores is cleared, one entry per cycle, with req_stall high; configuration
// writes are taken throughout.
module adam_optimizer_update #(
   parameter int ELEMENTS = adam_pkg::ELEMENTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  adam_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output adam_pkg::rsp_type          rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_index,
   input  logic [adam_pkg::CSR_W-1:0] csr_wdata
);
   import adam_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   adam_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .status(status), .cmd(cmd)
   );

   adam_dp #(.ELEMENTS(ELEMENTS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_payload(req_payload), .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );
endmodule

/* rtl/adam_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module adam_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [adam_pkg::DIV_W-1:0] dividend,
   input  logic [adam_pkg::DEN_W-1:0] divisor,
   output logic                       done,
   output logic [adam_pkg::DIV_W-1:0] quotient,
   output logic [adam_pkg::DEN_W-1:0] remainder
);
   import adam_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

   logic [DIV_W-1:0] work_ff, work_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   rem_sh, rem_sub;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, work_ff[DIV_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      ge      = rem_sh >= {1'b0, den_ff};
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[DIV_W-2:0], ge};
         rem_in  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;
endmodule

/* rtl/adam_sqrt.sv */
// digit-serial integer square root, one root bit per cycle
module adam_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [adam_pkg::VM_W-1:0]   radicand,
   output logic                        done,
   output logic [adam_pkg::ROOT_W-1:0] root
);
   import adam_pkg::*;

   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

   logic [VM_W-1:0]   x_ff, x_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_t, trial;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in, ge;

   always_comb begin
      rem_t   = {rem_ff[REM_W-3:0], x_ff[VM_W-1:VM_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_t >= trial;
      x_in    = x_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in    = {x_ff[VM_W-3:0], 2'b00};
         root_in = {root_ff[ROOT_W-2:0], ge};
         rem_in  = ge ? rem_t - trial : rem_t;
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

/* rtl/adam_dp.sv */
// datapath: moment stores, shared multiplier and accumulator, divider, root, output register
module adam_dp #(
   parameter int ELEMENTS = adam_pkg::ELEMENTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  adam_pkg::dp_cmd_type       cmd,
   output adam_pkg::dp_status_type    status,
   input  adam_pkg::req_type          req_payload,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output adam_pkg::rsp_type          rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [1:0]                 csr_index,
   input  logic [adam_pkg::CSR_W-1:0] csr_wdata
);
   import adam_pkg::*;

   localparam int ADDR_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(ELEMENTS - 1);
   localparam logic [ACC_W-1:0] HALF_ACC = ACC_W'(1) << (FRAC_W - 1);

   function automatic logic [31:0] index_wrap(input logic [INDEX_W-1:0] raw);
      logic [31:0] x;
      x = 32'(raw);
      for (int k = INDEX_W - 1; k >= 0; k--) begin
         if (x >= (32'(ELEMENTS) << k)) x = x - (32'(ELEMENTS) << k);
      end
      return x;
   endfunction

   logic [31:0]      m_mem [ELEMENTS];
   logic [VM_W-1:0]  v_mem [ELEMENTS];
   logic [31:0]      m_rd_ff;
   logic [VM_W-1:0]  v_rd_ff;

   logic [23:0]      b1_ff, b1_in, b2_ff, b2_in, alpha_ff, alpha_in;
   logic [EPS_W-1:0] eps_ff, eps_in;
   logic [COEF_W-1:0] p1_ff, p1_in, p2_ff, p2_in;

   logic signed [GRAD_W-1:0] g_ff, g_in;
   logic [INDEX_W-1:0] idx_raw_ff, idx_raw_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in, clr_ff, clr_in;
   logic               last_ff, last_in;

   logic [63:0]        prod_ff, prod_in;
   logic               pneg_ff, pneg_in;
   logic [ACC_W-1:0]   acc_ff, acc_in, term_mag, term;
   logic [31:0]        mul_a, mul_b;
   logic               mul_neg;

   logic signed [31:0] m_ff, m_in;
   logic [63:0]        gsq_ff, gsq_in;
   logic [VM_W-1:0]    v_ff, v_in, mh_ff, mh_in, vhat_ff, vhat_in;
   logic [COEF_W-1:0]  c1_ff, c1_in, c2_ff, c2_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [31:0]        res_val_ff, res_val_in;
   logic               res_sat_ff, res_sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [31:0]        g_mag, m_old_mag, m_mag;
   logic [COEF_W-1:0]  ob1, ob2;
   logic [DIV_W-1:0]   div_dividend, quot;
   logic [DEN_W-1:0]   div_divisor, rem;
   logic               div_done, sqrt_done;
   logic [ROOT_W-1:0]  root;
   logic [40:0]        res41;
   logic               over, rnd, neg;

   adam_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(div_dividend), .divisor(div_divisor),
      .done(div_done), .quotient(quot), .remainder(rem)
   );

   adam_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(cmd.sqrt_start),
      .radicand(vhat_ff), .done(sqrt_done), .root(root)
   );

   assign g_mag     = g_ff[GRAD_W-1] ? 32'(-g_ff) : 32'(g_ff);
   assign m_old_mag = m_rd_ff[31] ? 32'(-m_rd_ff) : m_rd_ff;
   assign m_mag     = m_ff[31] ? 32'(-m_ff) : 32'(m_ff);
   assign ob1       = ONE_Q24 - {1'b0, b1_ff};
   assign ob2       = ONE_Q24 - {1'b0, b2_ff};
   assign neg       = m_ff[31];

   always_comb begin
      mul_neg = 1'b0;
      unique case (cmd.mul_sel)
         MUL_G_SQ:  begin mul_a = g_mag; mul_b = g_mag; end
         MUL_G_M:   begin mul_a = g_mag; mul_b = 32'(ob1); mul_neg = g_ff[GRAD_W-1]; end
         MUL_M_OLD: begin mul_a = m_old_mag; mul_b = 32'(b1_ff); mul_neg = m_rd_ff[31]; end
         MUL_V_LO:  begin mul_a = v_rd_ff[31:0]; mul_b = 32'(b2_ff); end
         MUL_V_HI:  begin mul_a = v_rd_ff[63:32]; mul_b = 32'(b2_ff); end
         MUL_SQ_LO: begin mul_a = gsq_ff[31:0]; mul_b = 32'(ob2); end
         MUL_SQ_HI: begin mul_a = gsq_ff[63:32]; mul_b = 32'(ob2); end
         MUL_P1:    begin mul_a = 32'(p1_ff); mul_b = 32'(b1_ff); end
         MUL_P2:    begin mul_a = 32'(p2_ff); mul_b = 32'(b2_ff); end
         MUL_N_LO:  begin mul_a = mh_ff[31:0]; mul_b = 32'(alpha_ff); end
         MUL_N_HI:  begin mul_a = mh_ff[63:32]; mul_b = 32'(alpha_ff); end
         default:   begin mul_a = '0; mul_b = '0; end
      endcase
      prod_in = mul_a * mul_b;
      pneg_in = mul_neg;
   end

   always_comb begin
      term_mag = ACC_W'(prod_ff) << (cmd.acc_sh32 ? 32 : 0);
      term     = pneg_ff ? -term_mag : term_mag;
      case (cmd.acc_op)
         ACC_LOAD:     acc_in = term;
         ACC_LOAD_RND: acc_in = term + HALF_ACC;
         ACC_ADD:      acc_in = acc_ff + term;
         default:      acc_in = acc_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.div_sel)
         DIV_MH: begin
            div_dividend = {40'b0, m_mag, 24'b0} + {72'b0, c1_ff[COEF_W-1:1]};
            div_divisor  = {24'b0, c1_ff};
         end
         DIV_VH: begin
            div_dividend = {8'b0, v_ff, 24'b0} + {72'b0, c2_ff[COEF_W-1:1]};
            div_divisor  = {24'b0, c2_ff};
         end
         default: begin
            div_dividend = {acc_ff[79:0], 16'b0};
            div_divisor  = den_ff;
         end
      endcase
   end

   // final rounding, overflow and clipping
   always_comb begin
      if (cmd.cap == CAP_UPD_ZERO) begin
         res41 = '0;
         over  = |mh_ff;
      end else begin
         rnd   = {rem, 1'b0} >= {1'b0, den_ff};
         res41 = {1'b0, quot[39:0]} + 41'(rnd);
         over  = |quot[DIV_W-1:40];
      end
      rnd = {rem, 1'b0} >= {1'b0, den_ff};
      if (neg) begin
         if (over || res41 > 41'h0080000000) begin
            res_val_in = 32'h80000000;
            res_sat_in = 1'b1;
         end else begin
            res_val_in = 32'(-res41[31:0]);
            res_sat_in = 1'b0;
         end
      end else begin
         if (over || res41 > 41'h007FFFFFFF) begin
            res_val_in = 32'h7FFFFFFF;
            res_sat_in = 1'b1;
         end else begin
            res_val_in = res41[31:0];
            res_sat_in = 1'b0;
         end
      end
   end

   always_comb begin
      b1_in = b1_ff; b2_in = b2_ff; alpha_in = alpha_ff; eps_in = eps_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_DECAY:  b1_in    = csr_wdata[23:0];
            CSR_SECOND_DECAY: b2_in    = csr_wdata[23:0];
            CSR_STEP_SIZE:    alpha_in = csr_wdata[23:0];
            CSR_STABILITY:    eps_in   = csr_wdata[EPS_W-1:0];
            default:          b1_in    = b1_ff;
         endcase
      end
      g_in = g_ff; idx_raw_in = idx_raw_ff; idx_in = idx_ff; last_in = last_ff;
      if (cmd.accept) begin
         g_in       = req_payload.grad;
         idx_raw_in = req_payload.elem_index;
         idx_in     = ADDR_W'(index_wrap(req_payload.elem_index));
         last_in    = req_payload.last_elem;
      end
      clr_in = cmd.clear_we ? clr_ff + ADDR_W'(1) : clr_ff;
      m_in = m_ff; gsq_in = gsq_ff; v_in = v_ff; c1_in = c1_ff; c2_in = c2_ff;
      mh_in = mh_ff; vhat_in = vhat_ff; den_in = den_ff;
      p1_in = p1_ff; p2_in = p2_ff;
      case (cmd.cap)
         CAP_GSQ:  gsq_in = prod_ff;
         CAP_M:    m_in   = acc_ff[FRAC_W +: 32];
         CAP_V:    v_in   = acc_ff[FRAC_W +: VM_W];
         CAP_C1:   c1_in  = ONE_Q24 - acc_ff[FRAC_W +: COEF_W];
         CAP_C2: begin
            c2_in = ONE_Q24 - acc_ff[FRAC_W +: COEF_W];
            if (last_ff) begin
               p1_in = ONE_Q24 - c1_ff;
               p2_in = acc_ff[FRAC_W +: COEF_W];
            end
         end
         CAP_MH:   mh_in   = quot[VM_W-1:0];
         CAP_VHAT: vhat_in = (|quot[DIV_W-1:VM_W]) ? '1 : quot[VM_W-1:0];
         CAP_DEN:  den_in  = {1'b0, root, 16'b0} + {9'b0, eps_ff};
         default:  m_in    = m_ff;
      endcase
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_in.update_value = res_val_ff;
         rsp_in.out_index    = idx_raw_ff;
         rsp_in.saturated    = res_sat_ff;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_we || cmd.mem_we) begin
         m_mem[cmd.clear_we ? clr_ff : idx_ff] <= cmd.clear_we ? 32'b0 : m_ff;
         v_mem[cmd.clear_we ? clr_ff : idx_ff] <= cmd.clear_we ? '0 : v_ff;
      end
      if (cmd.mem_rd) begin
         m_rd_ff <= m_mem[idx_ff];
         v_rd_ff <= v_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_ff        <= FIRST_DECAY_RESET;
         b2_ff        <= SECOND_DECAY_RESET;
         alpha_ff     <= STEP_SIZE_RESET;
         eps_ff       <= STABILITY_RESET;
         p1_ff        <= ONE_Q24;
         p2_ff        <= ONE_Q24;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_ff        <= b1_in;
         b2_ff        <= b2_in;
         alpha_ff     <= alpha_in;
         eps_ff       <= eps_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      g_ff       <= g_in;
      idx_raw_ff <= idx_raw_in;
      idx_ff     <= idx_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      pneg_ff    <= pneg_in;
      acc_ff     <= acc_in;
      m_ff       <= m_in;
      gsq_ff     <= gsq_in;
      v_ff       <= v_in;
      c1_ff      <= c1_in;
      c2_ff      <= c2_in;
      mh_ff      <= mh_in;
      vhat_ff    <= vhat_in;
      den_ff     <= den_in;
      if (cmd.cap == CAP_UPD_ZERO || cmd.cap == CAP_UPD_DIV) begin
         res_val_ff <= res_val_in;
         res_sat_ff <= res_sat_in;
      end
      rsp_ff     <= rsp_in;
   end

   assign status.clear_last = clr_ff == ADDR_LAST;
   assign status.div_done   = div_done;
   assign status.sqrt_done  = sqrt_done;
   assign status.den_zero   = den_ff == '0;
   assign status.out_busy   = rsp_valid_ff && rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload       = rsp_ff;
endmodule

/* rtl/adam_ctrl.sv */
// sequencer that steps the datapath through one request
module adam_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  adam_pkg::dp_status_type status,
   output adam_pkg::dp_cmd_type    cmd
);
   import adam_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RD;
            end
         end
         ST_RD: begin
            cmd.mem_rd  = 1'b1;
            cmd.mul_sel = MUL_G_SQ;
            state_in    = ST_M0;
         end
         ST_M0: begin
            cmd.mul_sel = MUL_G_M;
            cmd.cap     = CAP_GSQ;
            state_in    = ST_M1;
         end
         ST_M1: begin
            cmd.mul_sel = MUL_M_OLD;
            cmd.acc_op  = ACC_LOAD_RND;
            state_in    = ST_M2;
         end
         ST_M2: begin
            cmd.mul_sel = MUL_V_LO;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_V0;
         end
         ST_V0: begin
            cmd.mul_sel = MUL_V_HI;
            cmd.acc_op  = ACC_LOAD_RND;
            cmd.cap     = CAP_M;
            state_in    = ST_V1;
         end
         ST_V1: begin
            cmd.mul_sel  = MUL_SQ_LO;
            cmd.acc_op   = ACC_ADD;
            cmd.acc_sh32 = 1'b1;
            state_in     = ST_V2;
         end
         ST_V2: begin
            cmd.mul_sel = MUL_SQ_HI;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_V3;
         end
         ST_V3: begin
            cmd.mul_sel  = MUL_P1;
            cmd.acc_op   = ACC_ADD;
            cmd.acc_sh32 = 1'b1;
            state_in     = ST_C1;
         end
         ST_C1: begin
            cmd.mul_sel = MUL_P2;
            cmd.acc_op  = ACC_LOAD_RND;
            cmd.cap     = CAP_V;
            state_in    = ST_C2;
         end
         ST_C2: begin
            cmd.acc_op = ACC_LOAD_RND;
            cmd.cap    = CAP_C1;
            cmd.mem_we = 1'b1;
            state_in   = ST_C3;
         end
         ST_C3: begin
            cmd.cap       = CAP_C2;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MH;
            state_in      = ST_DIV_MH;
         end
         ST_DIV_MH: begin
            if (status.div_done) begin
               cmd.cap       = CAP_MH;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_VH;
               state_in      = ST_DIV_VH;
            end
         end
         ST_DIV_VH: begin
            cmd.div_sel = DIV_VH;
            if (status.div_done) begin
               cmd.cap  = CAP_VHAT;
               state_in = ST_SQ0;
            end
         end
         ST_SQ0: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT;
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               cmd.cap  = CAP_DEN;
               state_in = ST_N0;
            end
         end
         ST_N0: begin
            cmd.mul_sel = MUL_N_LO;
            state_in    = ST_N1;
         end
         ST_N1: begin
            cmd.mul_sel = MUL_N_HI;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_N2;
         end
         ST_N2: begin
            cmd.acc_op   = ACC_ADD;
            cmd.acc_sh32 = 1'b1;
            state_in     = ST_N3;
         end
         ST_N3: begin
            cmd.div_sel = DIV_UP;
            if (status.den_zero) begin
               cmd.cap  = CAP_UPD_ZERO;
               state_in = ST_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_UP;
            end
         end
         ST_DIV_UP: begin
            cmd.div_sel = DIV_UP;
            if (status.div_done) begin
               cmd.cap  = CAP_UPD_DIV;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end
endmodule

/* rtl/adam_checker.sv */
// port-level checks of the adam optimizer update block, bound to the top level
`include "adam_optimizer_update_macros.svh"

module adam_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input adam_pkg::rsp_type rsp_payload
);
   import adam_pkg::*;

   `ADAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `ADAM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)
   `ADAM_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, req_stall)
   `ADAM_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))
endmodule

bind adam_optimizer_update adam_checker u_adam_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
);

/* test/adam_optimizer_update_tb.sv */
// testbench for the adam optimizer update block: queued random and directed requests
`timescale 1ns / 1ps
module adam_optimizer_update_tb;
   import adam_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 40;
   localparam logic [63:0] Q24_ONE  = 64'd1 << 24;
   localparam logic [63:0] Q24_HALF = 64'd1 << 23;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_wr_en = 1'b0;
   logic [1:0]    csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   req_type   pending_reqs[$];
   rsp_type   update_expected[$];
   int        send_idle_pct = 0;
   int        stall_pct = 0;
   int        mismatches = 0;
   int        quiet_cycles = 0;

   // model copy of the block state
   longint      first_mom[ELEMENTS_DEFAULT];
   logic [63:0] second_mom[ELEMENTS_DEFAULT];
   logic [63:0] pow1, pow2;
   logic [63:0] beta1, beta2, alpha, eps;

   adam_optimizer_update u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic rsp_type adam_update_predict(req_type r);
      rsp_type     o;
      longint      g, m;
      logic [63:0] gmag, v, c1, c2, mag, mh, q, rr, vh, root, den, res;
      logic [127:0] w, t, num, quo, rem;
      logic [9:0]  idx;
      logic        neg, over, sat;
      g = longint'(r.grad);
      idx = r.elem_index;
      over = 1'b0;
      sat = 1'b0;
      m = (longint'(beta1) * first_mom[idx] + longint'(Q24_ONE - beta1) * g
           + longint'(Q24_HALF)) >>> 24;
      first_mom[idx] = m;
      gmag = (g < 0) ? 64'(-g) : 64'(g);
      w = 128'(second_mom[idx]) * 128'(beta2) + 128'(gmag * gmag) * 128'(Q24_ONE - beta2)
          + 128'(Q24_HALF);
      v = w[87:24];
      second_mom[idx] = v;
      c1 = Q24_ONE - ((pow1 * beta1 + Q24_HALF) >> 24);
      c2 = Q24_ONE - ((pow2 * beta2 + Q24_HALF) >> 24);
      neg = m < 0;
      mag = neg ? 64'(-m) : 64'(m);
      mh = ((mag << 24) + c1 / 2) / c1;
      q = v / c2;
      rr = v % c2;
      vh = ((rr << 24) + c2 / 2) / c2;
      t = (128'(q) << 24) + 128'(vh);
      if (q >= (64'd1 << 40) || t[127:64] != 0) vh = '1;
      else vh = t[63:0];
      root = floor_root(vh);
      den = (root << 16) + eps;
      if (den == 0) begin
         res = 0;
         over = mh != 0;
      end else begin
         num = (128'(alpha) * 128'(mh)) << 16;
         quo = num / 128'(den);
         rem = num % 128'(den);
         over = quo >= (128'd1 << 40);
         res = 64'(quo[39:0]) + ((2 * rem >= 128'(den)) ? 64'd1 : 64'd0);
      end
      if (neg) begin
         if (over || res > 64'h8000_0000) begin
            res = 64'h8000_0000;
            sat = 1'b1;
         end
         o.update_value = 32'(-res);
      end else begin
         if (over || res > 64'h7FFF_FFFF) begin
            res = 64'h7FFF_FFFF;
            sat = 1'b1;
         end
         o.update_value = res[31:0];
      end
      o.out_index = r.elem_index;
      o.saturated = sat;
      if (r.last_elem) begin
         pow1 = (pow1 * beta1 + Q24_HALF) >> 24;
         pow2 = (pow2 * beta2 + Q24_HALF) >> 24;
      end
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            update_expected.push_back(adam_update_predict(req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (update_expected.size() == 0) begin
            if (mismatches < 10) $display("unexpected response %p", rsp_payload);
            mismatches++;
         end else begin
            rsp_type e;
            e = update_expected.pop_front();
            if (e !== rsp_payload) begin
               if (mismatches < 10) $display("mismatch: expected %p, got %p", e, rsp_payload);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type i, logic [CSR_W-1:0] d);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= i;
      csr_wdata <= d;
      case (i)
         CSR_FIRST_DECAY:  beta1 = 64'(d[23:0]);
         CSR_SECOND_DECAY: beta2 = 64'(d[23:0]);
         CSR_STEP_SIZE:    alpha = 64'(d[23:0]);
         default:          eps = 64'(d[39:0]);
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_all(logic [23:0] b1, logic [23:0] b2, logic [23:0] a,
                          logic [39:0] e);
      write_csr(CSR_FIRST_DECAY, {16'(0), b1});
      write_csr(CSR_SECOND_DECAY, {16'(0), b2});
      write_csr(CSR_STEP_SIZE, {16'(0), a});
      write_csr(CSR_STABILITY, e);
   endtask

   task automatic push_req(logic [31:0] g, logic [9:0] idx, logic last);
      req_type r;
      r.grad = g;
      r.elem_index = idx;
      r.last_elem = last;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || update_expected.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_grad();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(4000)) - 2000);
         3: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [39:0] e;
      for (int i = 0; i < ELEMENTS_DEFAULT; i++) begin
         first_mom[i] = 0;
         second_mom[i] = 0;
      end
      pow1 = Q24_ONE;
      pow2 = Q24_ONE;
      beta1 = 64'(FIRST_DECAY_RESET);
      beta2 = 64'(SECOND_DECAY_RESET);
      alpha = 64'(STEP_SIZE_RESET);
      eps = 64'(STABILITY_RESET);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zero denominator and huge second moment estimate
      set_all(24'd0, 24'hFFFFFF, 24'hFFFFFF, 40'd0);
      push_req(32'd100, 10'd5, 1'b0);
      push_req(-32'sd100, 10'd6, 1'b0);
      push_req(32'd0, 10'd7, 1'b0);
      repeat (6) push_req(32'h8000_0000, 10'd8, 1'b0);
      repeat (3) push_req(32'h7FFF_FFFF, 10'd9, 1'b0);
      drain();

      // field extremes with reset values restored
      set_all(FIRST_DECAY_RESET, SECOND_DECAY_RESET, STEP_SIZE_RESET, STABILITY_RESET);
      push_req(32'h7FFF_FFFF, 10'd0, 1'b0);
      push_req(32'h8000_0000, 10'd1023, 1'b1);
      push_req(32'hFFFF_FFFF, 10'd0, 1'b0);
      push_req(32'd1, 10'd1023, 1'b1);
      push_req(32'd0, 10'd512, 1'b0);
      push_req(32'h0100_0000, 10'h155, 1'b1);
      push_req(32'hFF00_0000, 10'h2AA, 1'b0);
      push_req(32'h5555_5555, 10'd0, 1'b1);
      push_req(32'hAAAA_AAAA, 10'd1023, 1'b0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         e = 40'({$urandom, $urandom} >> ($urandom_range(24)));
         case (ph)
            0: set_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 40'hFF_FFFF_FFFF);
            1: set_all(24'd0, 24'd0, 24'd0, 40'd0);
            2: set_all(FIRST_DECAY_RESET, SECOND_DECAY_RESET, STEP_SIZE_RESET,
                       STABILITY_RESET);
            default: set_all(24'($urandom), 24'($urandom), 24'($urandom), e);
         endcase
         for (int n = 0; n < 62; n++) begin
            push_req(rand_grad(),
                     ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15)),
                     $urandom_range(7) == 0);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
